// ===== rtl/serialized_pointer_resolver_core_defines.svh =====
// Assertion macros for the pointer resolver.
`ifndef SERIALIZED_POINTER_RESOLVER_CORE_DEFINES_SVH
`define SERIALIZED_POINTER_RESOLVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("spr assertion failed");
`define SPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spr assertion failed");
`else
`define SPR_ASSERT(lbl, prop)
`define SPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/spr_pkg.sv =====
package spr_pkg;

    localparam int STORE_WORDS_DEF = 4096;
    localparam int MAX_SEGS_DEF    = 16;

    localparam logic [31:0] TRAVERSAL_LIMIT_RST = 32'd8388608;
    localparam logic [6:0]  DEPTH_LIMIT_RST     = 7'd64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH     = 1'd1;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_DEFINE  = 2'd1;
    localparam logic [1:0] FUNC_WRITE   = 2'd2;
    localparam logic [1:0] FUNC_RESOLVE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BOUNDS    = 3'd1;
    localparam logic [2:0] ST_TRAVERSAL = 3'd2;
    localparam logic [2:0] ST_DEPTH     = 3'd3;
    localparam logic [2:0] ST_KIND      = 3'd4;
    localparam logic [2:0] ST_NOSEG     = 3'd5;

    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_STRUCT = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;
    localparam logic [1:0] KIND_CAP    = 2'd3;

    // pointer tag in the low two bits of a message word
    localparam logic [1:0] PTR_STRUCT = 2'd0;
    localparam logic [1:0] PTR_LIST   = 2'd1;
    localparam logic [1:0] PTR_FAR    = 2'd2;
    localparam logic [1:0] PTR_OTHER  = 2'd3;

    localparam logic [2:0] ES_VOID      = 3'd0;
    localparam logic [2:0] ES_BIT       = 3'd1;
    localparam logic [2:0] ES_BYTE      = 3'd2;
    localparam logic [2:0] ES_TWO       = 3'd3;
    localparam logic [2:0] ES_FOUR      = 3'd4;
    localparam logic [2:0] ES_EIGHT     = 3'd5;
    localparam logic [2:0] ES_PTR       = 3'd6;
    localparam logic [2:0] ES_COMPOSITE = 3'd7;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 152;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_DEFINE,
        OP_WRITE,
        OP_INIT,
        OP_FAIL,
        OP_CHK,
        OP_HOP,
        OP_FAR2,
        OP_NULL,
        OP_STRUCT,
        OP_LIST,
        OP_CAP,
        OP_PRIM,
        OP_COMP,
        OP_TAG,
        OP_MUL,
        OP_F2CHK,
        OP_PAD,
        OP_TAG2,
        OP_F2READ,
        OP_INC,
        OP_SPEND
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] code;
        logic       load_out;
    } t_cmd;

    typedef struct packed {
        logic       count_zero;
        logic       in_seg;
        logic       in_seg_nx;
        logic       tword_in;
        logic       budget_ge1;
        logic       budget_ge2;
        logic       need_gt;
        logic       range_bad;
        logic       depth_zero;
        logic       w_zero;
        logic [1:0] w_kind;
        logic       w_far2;
        logic       es7;
    } t_flags;

    // words covered by a primitive list: ceil(count * bits / 64)
    function automatic logic [28:0] elem_words(input logic [2:0] es, input logic [28:0] cnt);
        logic [35:0] bits_total;
        begin
            case (es)
                ES_BIT:   bits_total = 36'(cnt);
                ES_BYTE:  bits_total = 36'(cnt) << 3;
                ES_TWO:   bits_total = 36'(cnt) << 4;
                ES_FOUR:  bits_total = 36'(cnt) << 5;
                ES_EIGHT: bits_total = 36'(cnt) << 6;
                ES_PTR:   bits_total = 36'(cnt) << 6;
                default:  bits_total = 36'd0;
            endcase
            return 29'((bits_total + 36'd63) >> 6);
        end
    endfunction

endpackage

// ===== rtl/spr_ctrl.sv =====
module spr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [1:0]      i_func,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  spr_pkg::t_flags i_flags,
    output spr_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_DECODE,
        S_RANGE,
        S_SPEND,
        S_PRIM,
        S_COMP,
        S_TAG,
        S_MUL,
        S_F2CHK,
        S_PAD,
        S_TAG2,
        S_F2COMP,
        S_F2T,
        S_F2MUL,
        S_F2INC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;

    function automatic spr_pkg::t_cmd mk(input spr_pkg::t_op op, input logic [2:0] code);
        spr_pkg::t_cmd c;
        begin
            c.op       = op;
            c.code     = code;
            c.load_out = 1'b0;
            return c;
        end
    endfunction

    always_comb begin
        n_state = r_state;
        o_cmd   = mk(spr_pkg::OP_NONE, spr_pkg::ST_OK);
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DONE;
                    case (i_func)
                        spr_pkg::FUNC_START:  o_cmd = mk(spr_pkg::OP_START, spr_pkg::ST_OK);
                        spr_pkg::FUNC_DEFINE: o_cmd = mk(spr_pkg::OP_DEFINE, spr_pkg::ST_OK);
                        spr_pkg::FUNC_WRITE:  o_cmd = mk(spr_pkg::OP_WRITE, spr_pkg::ST_OK);
                        default: begin
                            if (i_flags.count_zero) begin
                                o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_NOSEG);
                            end else begin
                                o_cmd   = mk(spr_pkg::OP_INIT, spr_pkg::ST_OK);
                                n_state = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_CHK: begin
                n_state = S_DONE;
                if (!i_flags.in_seg) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_BOUNDS);
                end else if (!i_flags.budget_ge1) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_TRAVERSAL);
                end else begin
                    o_cmd   = mk(spr_pkg::OP_CHK, spr_pkg::ST_OK);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                if (i_flags.depth_zero) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_DEPTH);
                end else if (i_flags.w_zero) begin
                    o_cmd = mk(spr_pkg::OP_NULL, spr_pkg::ST_OK);
                end else begin
                    case (i_flags.w_kind)
                        spr_pkg::PTR_FAR: begin
                            if (i_flags.w_far2) begin
                                o_cmd   = mk(spr_pkg::OP_FAR2, spr_pkg::ST_OK);
                                n_state = S_F2CHK;
                            end else begin
                                o_cmd   = mk(spr_pkg::OP_HOP, spr_pkg::ST_OK);
                                n_state = S_CHK;
                            end
                        end
                        spr_pkg::PTR_STRUCT: begin
                            o_cmd   = mk(spr_pkg::OP_STRUCT, spr_pkg::ST_OK);
                            n_state = S_RANGE;
                        end
                        spr_pkg::PTR_LIST: begin
                            o_cmd   = mk(spr_pkg::OP_LIST, spr_pkg::ST_OK);
                            n_state = i_flags.es7 ? S_COMP : S_PRIM;
                        end
                        default: o_cmd = mk(spr_pkg::OP_CAP, spr_pkg::ST_OK);
                    endcase
                end
            end
            S_PRIM: begin
                o_cmd   = mk(spr_pkg::OP_PRIM, spr_pkg::ST_OK);
                n_state = S_RANGE;
            end
            S_COMP: begin
                n_state = S_DONE;
                if (!i_flags.tword_in) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_BOUNDS);
                end else if (!i_flags.budget_ge1) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_TRAVERSAL);
                end else begin
                    o_cmd   = mk(spr_pkg::OP_COMP, spr_pkg::ST_OK);
                    n_state = S_TAG;
                end
            end
            S_TAG: begin
                o_cmd   = mk(spr_pkg::OP_TAG, spr_pkg::ST_OK);
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd   = mk(spr_pkg::OP_MUL, spr_pkg::ST_OK);
                n_state = S_RANGE;
            end
            S_RANGE: begin
                if (i_flags.range_bad) begin
                    o_cmd   = mk(spr_pkg::OP_FAIL, spr_pkg::ST_BOUNDS);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SPEND;
                end
            end
            S_SPEND: begin
                n_state = S_DONE;
                if (i_flags.need_gt) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_TRAVERSAL);
                end else begin
                    o_cmd = mk(spr_pkg::OP_SPEND, spr_pkg::ST_OK);
                end
            end
            S_F2CHK: begin
                n_state = S_DONE;
                if (!(i_flags.in_seg && i_flags.in_seg_nx)) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_BOUNDS);
                end else if (!i_flags.budget_ge2) begin
                    o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_TRAVERSAL);
                end else begin
                    o_cmd   = mk(spr_pkg::OP_F2CHK, spr_pkg::ST_OK);
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                if (i_flags.w_kind == spr_pkg::PTR_FAR && !i_flags.w_far2) begin
                    o_cmd   = mk(spr_pkg::OP_PAD, spr_pkg::ST_OK);
                    n_state = S_TAG2;
                end else begin
                    o_cmd   = mk(spr_pkg::OP_FAIL, spr_pkg::ST_KIND);
                    n_state = S_DONE;
                end
            end
            S_TAG2: begin
                n_state = S_DONE;
                case (i_flags.w_kind)
                    spr_pkg::PTR_STRUCT: begin
                        o_cmd   = mk(spr_pkg::OP_TAG2, spr_pkg::ST_OK);
                        n_state = S_SPEND;
                    end
                    spr_pkg::PTR_LIST: begin
                        o_cmd = mk(spr_pkg::OP_TAG2, spr_pkg::ST_OK);
                        if (i_flags.es7) begin
                            n_state = S_F2COMP;
                        end
                    end
                    default: o_cmd = mk(spr_pkg::OP_FAIL, spr_pkg::ST_KIND);
                endcase
            end
            S_F2COMP: begin
                if (i_flags.in_seg) begin
                    o_cmd   = mk(spr_pkg::OP_F2READ, spr_pkg::ST_OK);
                    n_state = S_F2T;
                end else begin
                    o_cmd   = mk(spr_pkg::OP_FAIL, spr_pkg::ST_BOUNDS);
                    n_state = S_DONE;
                end
            end
            S_F2T: begin
                o_cmd   = mk(spr_pkg::OP_TAG, spr_pkg::ST_OK);
                n_state = S_F2MUL;
            end
            S_F2MUL: begin
                o_cmd   = mk(spr_pkg::OP_MUL, spr_pkg::ST_OK);
                n_state = S_F2INC;
            end
            S_F2INC: begin
                o_cmd   = mk(spr_pkg::OP_INC, spr_pkg::ST_OK);
                n_state = S_SPEND;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !m_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/spr_dp.sv =====
module spr_dp #(
    parameter int STORE_WORDS = spr_pkg::STORE_WORDS_DEF,
    parameter int MAX_SEGS    = spr_pkg::MAX_SEGS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spr_pkg::t_cmd                   i_cmd,
    input  logic                            i_cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [3:0]                      i_seg_index,
    input  logic [11:0]                     i_word_index,
    input  logic [63:0]                     i_data_word,
    input  logic [4:0]                      i_seg_count,
    input  logic [11:0]                     i_seg_base,
    input  logic [12:0]                     i_seg_size,
    output spr_pkg::t_flags                 o_flags,
    output logic [2:0]                      o_status,
    output logic [1:0]                      o_ptr_kind,
    output logic [31:0]                     o_target_segment,
    output logic [31:0]                     o_target_word,
    output logic [15:0]                     o_data_words,
    output logic [15:0]                     o_pointer_words,
    output logic [2:0]                      o_element_size,
    output logic [31:0]                     o_element_count,
    output logic [16:0]                     o_stride_words
);

    // store addressing wraps on the low address bits
    localparam int AW = $clog2(STORE_WORDS);
    localparam int SW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
    localparam int CW = $clog2(MAX_SEGS + 1);

    logic [63:0] mem_store [STORE_WORDS];
    logic [11:0] mem_base  [MAX_SEGS];
    logic [12:0] mem_size  [MAX_SEGS];

    logic [31:0] r_tlimit;
    logic [6:0]  r_dlimit;
    logic [CW-1:0] r_count;
    logic [31:0] r_budget;

    logic [31:0] r_seg, r_word, n_seg;
    logic [6:0]  r_depth;
    logic [63:0] r_rdata;
    logic [11:0] r_tbl_base;
    logic [12:0] r_tbl_size;
    logic [47:0] r_need;

    logic [2:0]  r_status;
    logic [1:0]  r_kind;
    logic [31:0] r_tseg, r_tword, r_cnt;
    logic [15:0] r_dw, r_pw;
    logic [2:0]  r_es;
    logic [16:0] r_stride;

    logic [31:0] near_tgt;
    logic [31:0] rd_sum;
    logic        rd_en;
    logic [SW-1:0] tbl_idx;
    logic [31:0] def_idx;
    logic [31:0] wr_idx;

    assign near_tgt = r_word + 32'd1 + {{2{r_rdata[31]}}, r_rdata[31:2]};
    assign def_idx  = 32'(i_seg_index);
    assign wr_idx   = 32'(i_word_index);

    always_comb begin
        o_flags.count_zero = (r_count == '0);
        o_flags.in_seg     = (r_seg < 32'(r_count)) && (r_word < 32'(r_tbl_size));
        o_flags.in_seg_nx  = (r_seg < 32'(r_count))
                          && ((33'(r_word) + 33'd1) < 33'(r_tbl_size));
        o_flags.tword_in   = (r_tword < 32'(r_tbl_size));
        o_flags.budget_ge1 = (r_budget != 32'd0);
        o_flags.budget_ge2 = (r_budget >= 32'd2);
        o_flags.need_gt    = (r_need > 48'(r_budget));
        o_flags.range_bad  = (r_need != 48'd0)
                          && ((49'(r_tword) + 49'(r_need) - 49'd1) >= 49'(r_tbl_size));
        o_flags.depth_zero = (r_depth == 7'd0);
        o_flags.w_zero     = (r_rdata == 64'd0);
        o_flags.w_kind     = r_rdata[1:0];
        o_flags.w_far2     = r_rdata[2];
        o_flags.es7        = (r_rdata[34:32] == spr_pkg::ES_COMPOSITE);
    end

    always_comb begin
        case (i_cmd.op)
            spr_pkg::OP_INIT: n_seg = 32'(i_seg_index);
            spr_pkg::OP_HOP,
            spr_pkg::OP_FAR2,
            spr_pkg::OP_PAD:  n_seg = r_rdata[63:32];
            default:          n_seg = r_seg;
        endcase
        tbl_idx = n_seg[SW-1:0];
    end

    always_comb begin
        rd_en  = 1'b0;
        rd_sum = 32'(r_tbl_base) + r_word;
        case (i_cmd.op)
            spr_pkg::OP_CHK,
            spr_pkg::OP_F2CHK,
            spr_pkg::OP_F2READ: rd_en = 1'b1;
            spr_pkg::OP_COMP: begin
                rd_en  = 1'b1;
                rd_sum = 32'(r_tbl_base) + r_tword;
            end
            spr_pkg::OP_PAD: begin
                rd_en  = 1'b1;
                rd_sum = 32'(r_tbl_base) + r_word + 32'd1;
            end
            default: rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == spr_pkg::OP_WRITE) begin
            mem_store[wr_idx[AW-1:0]] <= i_data_word;
        end
        if (rd_en) begin
            r_rdata <= mem_store[rd_sum[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == spr_pkg::OP_DEFINE && def_idx < 32'(MAX_SEGS)) begin
            mem_base[def_idx[SW-1:0]] <= i_seg_base;
            mem_size[def_idx[SW-1:0]] <= i_seg_size;
        end
        r_tbl_base <= mem_base[tbl_idx];
        r_tbl_size <= mem_size[tbl_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlimit <= spr_pkg::TRAVERSAL_LIMIT_RST;
            r_dlimit <= spr_pkg::DEPTH_LIMIT_RST;
            r_count  <= '0;
            r_budget <= spr_pkg::TRAVERSAL_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    spr_pkg::CFG_TRAVERSAL: r_tlimit <= i_cfg_data;
                    spr_pkg::CFG_DEPTH:     r_dlimit <= i_cfg_data[6:0];
                    default:                r_tlimit <= r_tlimit;
                endcase
            end
            case (i_cmd.op)
                spr_pkg::OP_START: begin
                    r_count  <= (32'(i_seg_count) > 32'(MAX_SEGS)) ? CW'(MAX_SEGS)
                                                                  : CW'(i_seg_count);
                    r_budget <= r_tlimit;
                end
                spr_pkg::OP_CHK,
                spr_pkg::OP_COMP:  r_budget <= r_budget - 32'd1;
                spr_pkg::OP_F2CHK: r_budget <= r_budget - 32'd2;
                spr_pkg::OP_SPEND: r_budget <= r_budget - r_need[31:0];
                default:           r_budget <= r_budget;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            spr_pkg::OP_START,
            spr_pkg::OP_DEFINE,
            spr_pkg::OP_WRITE,
            spr_pkg::OP_INIT,
            spr_pkg::OP_FAIL: begin
                r_status <= (i_cmd.op == spr_pkg::OP_FAIL) ? i_cmd.code : spr_pkg::ST_OK;
                r_kind   <= spr_pkg::KIND_NULL;
                r_tseg   <= '0;
                r_tword  <= '0;
                r_dw     <= '0;
                r_pw     <= '0;
                r_es     <= '0;
                r_cnt    <= '0;
                r_stride <= '0;
                r_need   <= '0;
                if (i_cmd.op == spr_pkg::OP_INIT) begin
                    r_seg   <= n_seg;
                    r_word  <= wr_idx;
                    r_depth <= r_dlimit;
                end
            end
            spr_pkg::OP_HOP: begin
                r_seg   <= n_seg;
                r_word  <= {3'd0, r_rdata[31:3]};
                r_depth <= r_depth - 7'd1;
            end
            spr_pkg::OP_FAR2: begin
                r_seg  <= n_seg;
                r_word <= {3'd0, r_rdata[31:3]};
            end
            spr_pkg::OP_NULL: begin
                r_tseg  <= r_seg;
                r_tword <= r_word;
            end
            spr_pkg::OP_STRUCT: begin
                r_kind  <= spr_pkg::KIND_STRUCT;
                r_tseg  <= r_seg;
                r_tword <= near_tgt;
                r_dw    <= r_rdata[47:32];
                r_pw    <= r_rdata[63:48];
                r_need  <= 48'(r_rdata[47:32]) + 48'(r_rdata[63:48]);
            end
            spr_pkg::OP_LIST: begin
                r_kind  <= spr_pkg::KIND_LIST;
                r_tseg  <= r_seg;
                r_tword <= near_tgt;
                r_es    <= r_rdata[34:32];
                r_cnt   <= {3'd0, r_rdata[63:35]};
            end
            spr_pkg::OP_CAP: begin
                r_kind  <= spr_pkg::KIND_CAP;
                r_tseg  <= r_seg;
                r_tword <= r_word;
                r_cnt   <= r_rdata[63:32];
            end
            spr_pkg::OP_PRIM: r_need <= 48'(spr_pkg::elem_words(r_es, r_cnt[28:0]));
            spr_pkg::OP_TAG: begin
                r_cnt    <= {2'd0, r_rdata[31:2]};
                r_dw     <= r_rdata[47:32];
                r_pw     <= r_rdata[63:48];
                r_stride <= 17'(r_rdata[47:32]) + 17'(r_rdata[63:48]);
                r_tword  <= r_tword + 32'd1;
            end
            spr_pkg::OP_MUL: r_need <= 48'(r_cnt[29:0]) * 48'(r_stride);
            spr_pkg::OP_INC: r_need <= r_need + 48'd1;
            spr_pkg::OP_PAD: begin
                r_seg   <= n_seg;
                r_word  <= {3'd0, r_rdata[31:3]};
                r_tseg  <= n_seg;
                r_tword <= {3'd0, r_rdata[31:3]};
            end
            spr_pkg::OP_TAG2: begin
                if (r_rdata[1:0] == spr_pkg::PTR_STRUCT) begin
                    r_kind <= spr_pkg::KIND_STRUCT;
                    r_dw   <= r_rdata[47:32];
                    r_pw   <= r_rdata[63:48];
                    r_need <= 48'(r_rdata[47:32]) + 48'(r_rdata[63:48]);
                end else begin
                    r_kind <= spr_pkg::KIND_LIST;
                    r_es   <= r_rdata[34:32];
                    r_cnt  <= {3'd0, r_rdata[63:35]};
                end
            end
            default: r_need <= r_need;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status         <= r_status;
            o_ptr_kind       <= r_kind;
            o_target_segment <= r_tseg;
            o_target_word    <= r_tword;
            o_data_words     <= r_dw;
            o_pointer_words  <= r_pw;
            o_element_size   <= r_es;
            o_element_count  <= r_cnt;
            o_stride_words   <= r_stride;
        end
    end

endmodule

// ===== rtl/serialized_pointer_resolver_core.sv =====
// Pointer resolver for a segmented message held in an on-chip word store.
// Input stream: tuser carries the function (start, define segment, write word,
// resolve); tdata carries the item fields. Each accepted transaction yields
// exactly one output transaction: status and pointer kind plus the target
// descriptor (segment, word, struct sizes, list size code, count, stride).
// Start, define and write go from accept through the done state to the result.
// A resolve walks the store through a sequencer: each store load or segment
// table lookup is one sequencer step, each single-far hop repeats the check
// and decode steps, and a double-far resolve adds its landing-pad steps. The
// sequencer takes one step per cycle unless it waits on a full output register.
// The input is taken only while the sequencer is idle; one finished result
// may wait in the output register while the next transaction is accepted.
// If the receiver stalls with a result waiting, the next result holds the
// sequencer until the output register frees.
// Reset clears the segment count, reloads the traversal budget and sets the
// limits to their defaults; store and segment table contents are undefined
// until written. Configuration may be written only while nothing is in flight.
`include "serialized_pointer_resolver_core_defines.svh"

module serialized_pointer_resolver_core #(
    parameter int STORE_WORDS = spr_pkg::STORE_WORDS_DEF,
    parameter int MAX_SEGS    = spr_pkg::MAX_SEGS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // seg_index, word_index, data_word, seg_count, seg_base, seg_size
    input  logic [spr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // func
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, target_segment, target_word, data_words, pointer_words,
    // element_size, element_count, stride_words
    output logic [spr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // ptr_kind
    output logic [1:0]                         m_axis_tuser
);

    spr_pkg::t_cmd   cmd;
    spr_pkg::t_flags flags;

    logic [2:0]  status;
    logic [31:0] tseg, tword, cnt;
    logic [15:0] dw, pw;
    logic [2:0]  es;
    logic [16:0] stride;

    spr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_func        (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_flags       (flags),
        .o_cmd         (cmd)
    );

    spr_dp #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_SEGS    (MAX_SEGS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_seg_index      (s_axis_tdata[3:0]),
        .i_word_index     (s_axis_tdata[15:4]),
        .i_data_word      (s_axis_tdata[79:16]),
        .i_seg_count      (s_axis_tdata[84:80]),
        .i_seg_base       (s_axis_tdata[96:85]),
        .i_seg_size       (s_axis_tdata[109:97]),
        .o_flags          (flags),
        .o_status         (status),
        .o_ptr_kind       (m_axis_tuser),
        .o_target_segment (tseg),
        .o_target_word    (tword),
        .o_data_words     (dw),
        .o_pointer_words  (pw),
        .o_element_size   (es),
        .o_element_count  (cnt),
        .o_stride_words   (stride)
    );

    assign m_axis_tdata = {1'b0, stride, cnt, es, pw, dw, tword, tseg, status};

    `SPR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SPR_ASSERT(a_err_fields_zero, m_axis_tvalid && (m_axis_tdata[2:0] != spr_pkg::ST_OK) |-> (m_axis_tuser == spr_pkg::KIND_NULL && m_axis_tdata[150:3] == '0))
    `SPR_ASSERT(a_status_legal, m_axis_tvalid |-> m_axis_tdata[2:0] <= spr_pkg::ST_NOSEG)

endmodule
